>>> design/running_simpson_integrator_defines.svh
// Assertion macros shared by the running Simpson integrator RTL.
`ifndef RUNNING_SIMPSON_INTEGRATOR_DEFINES_SVH
`define RUNNING_SIMPSON_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define RSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define RSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/rsi_pkg.sv
// Shared widths, term codes and lane control type for the Simpson integrator.
package rsi_pkg;

  localparam int FIELDS       = 4;
  localparam int CHANNELS_DEF = 4;
  localparam int TW    = 32;               // time stamp
  localparam int VW    = 32;               // sample value
  localparam int AW    = 48;               // running area
  localparam int CW    = 65;               // term coefficient
  localparam int DW    = 51;               // term divisor
  localparam int YW    = 35;               // combined sample sum
  localparam int MW    = 33;               // sum magnitude
  localparam int NW    = 98;               // full product
  localparam int QW    = 51;               // clamped quotient
  localparam int RW    = 53;               // signed term result
  localparam int DLW   = 56;               // delta accumulator
  localparam int IN_W  = TW + FIELDS * VW;
  localparam int OUT_W = FIELDS * AW;

  localparam logic [1:0] TERM_TRAP  = 2'd0;
  localparam logic [1:0] TERM_SUM3  = 2'd1;
  localparam logic [1:0] TERM_LEFT  = 2'd2;
  localparam logic [1:0] TERM_RIGHT = 2'd3;

  localparam logic [QW-1:0] TERM_LIMIT = {1'b1, 50'd0};
  localparam logic [DW-1:0] DIV_TRAP   = 51'd131072;
  localparam logic [DW-1:0] DIV_SUM3   = 51'd196608;

  localparam logic signed [DLW-1:0] AREA_MAX = {{(DLW-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [DLW-1:0] AREA_MIN = {{(DLW-AW+1){1'b1}}, {(AW-1){1'b0}}};

  typedef struct packed {
    logic          clear_area;
    logic          load_first;
    logic          load_mid;
    logic          load_y3;
    logic          first_from_y3;
    logic          clear_delta;
    logic          start;
    logic [1:0]    sel;
    logic          subtract;
    logic          apply;
    logic [CW-1:0] coef;
    logic [DW-1:0] divisor;
  } lane_ctl_t;

endpackage

>>> design/rsi_term.sv
// One scaled term: floor(coef*y/divisor), clamped, by partial products and bit-serial divide.
module rsi_term import rsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [CW-1:0]        coef,
  input  logic [DW-1:0]        divisor,
  input  logic signed [YW-1:0] y,
  output logic                 done,
  output logic signed [RW-1:0] res
);

  localparam int CNT_W = $clog2(NW);

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_LO   = 3'd1;
  localparam logic [2:0] T_HI   = 3'd2;
  localparam logic [2:0] T_SUM  = 3'd3;
  localparam logic [2:0] T_DIV  = 3'd4;
  localparam logic [2:0] T_FIN  = 3'd5;

  logic [2:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic [MW-1:0]      mag;
  logic [CW-1:0]      coef_r;
  logic [DW-1:0]      div_r;
  logic [64:0]        p_lo;
  logic [65:0]        p_hi;
  logic [NW-1:0]      num;
  logic [DW-1:0]      rem;
  logic [NW-1:0]      quo;

  logic [YW-1:0]      y_abs;
  logic [DW:0]        rem_sh;
  logic [DW:0]        rem_sub;
  logic               fits;
  logic               over;
  logic [QW-1:0]      q_clamp;
  logic [QW-1:0]      q_adj;
  logic signed [RW-1:0] q_ext;

  assign y_abs   = y[YW-1] ? -y : y;
  assign rem_sh  = {rem, num[NW-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign fits    = rem_sh >= {1'b0, div_r};
  assign over    = (|quo[NW-1:QW]) || (quo[QW-1:0] > TERM_LIMIT);
  assign q_clamp = over ? TERM_LIMIT : quo[QW-1:0];
  // floor towards minus infinity: bump the magnitude when a negative value leaves a remainder
  assign q_adj   = q_clamp + QW'(neg && (|rem));
  assign q_ext   = {{(RW-QW){1'b0}}, q_adj};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_IDLE: begin
          if (start) begin
            neg    <= y[YW-1];
            mag    <= y_abs[MW-1:0];
            coef_r <= coef;
            div_r  <= divisor;
            state  <= T_LO;
          end
        end
        T_LO: begin
          p_lo  <= coef_r[31:0] * mag;
          state <= T_HI;
        end
        T_HI: begin
          p_hi  <= coef_r[CW-1:32] * mag;
          state <= T_SUM;
        end
        T_SUM: begin
          num   <= {{(NW-65){1'b0}}, p_lo} + {p_hi, 32'd0};
          rem   <= '0;
          quo   <= '0;
          cnt   <= '0;
          state <= T_DIV;
        end
        T_DIV: begin
          rem <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
          quo <= {quo[NW-2:0], fits};
          num <= {num[NW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NW - 1)) begin
            state <= T_FIN;
          end
        end
        T_FIN: begin
          res   <= neg ? -q_ext : q_ext;
          done  <= 1'b1;
          state <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/rsi_lane.sv
// One channel lane: held samples, term unit, delta accumulation and saturating area.
module rsi_lane import rsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  lane_ctl_t            ctl,
  input  logic signed [VW-1:0] value,
  output logic                 done,
  output logic signed [AW-1:0] area
);

  logic signed [VW-1:0]  first_v;
  logic signed [VW-1:0]  mid_v;
  logic signed [VW-1:0]  y3_v;
  logic signed [DLW-1:0] delta;

  logic signed [YW-1:0]  f_x;
  logic signed [YW-1:0]  m_x;
  logic signed [YW-1:0]  t_x;
  logic signed [YW-1:0]  y_sel;
  logic signed [RW-1:0]  res;
  logic signed [DLW-1:0] res_x;
  logic signed [DLW-1:0] sum;
  logic signed [AW-1:0]  area_next;

  assign f_x = {{(YW-VW){first_v[VW-1]}}, first_v};
  assign m_x = {{(YW-VW){mid_v[VW-1]}}, mid_v};
  assign t_x = {{(YW-VW){y3_v[VW-1]}}, y3_v};

  always_comb begin
    case (ctl.sel)
      TERM_TRAP:  y_sel = f_x + m_x;
      TERM_SUM3:  y_sel = f_x + m_x + t_x;
      TERM_LEFT:  y_sel = m_x - f_x;
      TERM_RIGHT: y_sel = m_x - t_x;
      default:    y_sel = f_x + m_x;
    endcase
  end

  rsi_term u_term (
    .clk     (clk),
    .rst     (rst),
    .start   (ctl.start),
    .coef    (ctl.coef),
    .divisor (ctl.divisor),
    .y       (y_sel),
    .done    (done),
    .res     (res)
  );

  assign res_x = {{(DLW-RW){res[RW-1]}}, res};
  assign sum   = {{(DLW-AW){area[AW-1]}}, area} + delta;

  always_comb begin
    if (sum > AREA_MAX) begin
      area_next = AREA_MAX[AW-1:0];
    end else if (sum < AREA_MIN) begin
      area_next = AREA_MIN[AW-1:0];
    end else begin
      area_next = sum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area    <= '0;
      first_v <= '0;
      mid_v   <= '0;
    end else begin
      if (ctl.clear_area) begin
        area <= '0;
      end else if (ctl.apply) begin
        area <= area_next;
      end
      if (ctl.load_first) begin
        first_v <= value;
      end else if (ctl.apply && ctl.first_from_y3) begin
        first_v <= y3_v;
      end
      if (ctl.load_mid) begin
        mid_v <= value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_y3) begin
      y3_v <= value;
    end
    if (ctl.clear_delta) begin
      delta <= '0;
    end else if (done) begin
      delta <= ctl.subtract ? delta - res_x : delta + res_x;
    end
  end

endmodule

>>> design/running_simpson_integrator.sv
// Top level: sample sequencer, shared spacing arithmetic, channel lanes and result register.
//
//  channel | dir | tdata (low bit up)                          | tuser (low bit up)
//  s_      | in  | time_stamp, value_a, value_b, value_c, ...d | restart
//  m_      | out | area_a, area_b, area_c, area_d              | pair_closed, degenerate
//
// Steps: a first sample passes through S_APPLY and S_OUT to the result register. Every other
// sample runs its terms in turn (one for a trapezoid or a degenerate close, four for a full
// panel close) through a shared-control, per-lane term unit: two partial products, a sum,
// a 98-step bit-serial divide and a finishing step, each term after a start state (S_PREP).
// Reset (rst, synchronous) clears phase, held times, held samples and all areas.
// One result is held; the next beat is taken while it waits, but that beat's result
// waits in turn until m_tready frees the register.
`include "running_simpson_integrator_defines.svh"
module running_simpson_integrator import rsi_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // time_stamp, value_a, value_b, value_c, value_d
  input  logic [0:0]       s_tuser,   // restart
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // area_a, area_b, area_c, area_d
  output logic [1:0]       m_tuser    // pair_closed, degenerate
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [1:0] PH_EMPTY = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;

  logic [2:0]    state;
  logic [1:0]    phase;
  logic [TW-1:0] first_time;
  logic [TW-1:0] mid_time;
  logic [TW-1:0] h1;
  logic [TW-1:0] h2;
  logic [TW:0]   hs;
  logic [CW-1:0] a_h1;     // hs * h1
  logic [CW-1:0] a_h2;     // hs * h2
  logic [1:0]    term;
  logic [1:0]    last_term;
  logic          closed;
  logic          degen;
  logic          sub_trap; // panel close takes the trapezoid back out

  logic          accept;
  logic [TW-1:0] t_in;
  logic [1:0]    ph_eff;
  logic [TW-1:0] h1_in;
  logic [TW-1:0] h2_in;
  logic          degen_in;
  logic          all_done;
  logic          out_free;
  logic [TW+2:0] six_h1;
  logic [TW+2:0] six_h2;

  lane_ctl_t     ctl;
  logic [CHANNELS-1:0]          lane_done;
  logic signed [AW-1:0]         lane_area [CHANNELS];
  logic [OUT_W-1:0]             out_data;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign t_in     = s_tdata[TW-1:0];
  // restart drops any pairing before this sample is used
  assign ph_eff   = s_tuser[0] ? PH_EMPTY : phase;
  assign h1_in    = (ph_eff == PH_ONE) ? (t_in - first_time) : (mid_time - first_time);
  assign h2_in    = t_in - mid_time;
  assign degen_in = (ph_eff == PH_TWO) && ((h1_in == '0) || (h2_in == '0));
  assign all_done = &lane_done;
  assign out_free = !m_tvalid || m_tready;
  assign six_h1   = {h1, 2'b00} + {1'b0, h1, 1'b0};
  assign six_h2   = {h2, 2'b00} + {1'b0, h2, 1'b0};

  // lane control, common to all lanes
  always_comb begin
    ctl               = '0;
    ctl.clear_area    = accept && s_tuser[0];
    ctl.load_first    = accept && (ph_eff != PH_ONE) && (ph_eff != PH_TWO);
    ctl.load_mid      = accept && (ph_eff == PH_ONE);
    ctl.load_y3       = accept && (ph_eff == PH_TWO);
    ctl.clear_delta   = accept;
    ctl.start         = (state == S_PREP);
    ctl.sel           = term;
    ctl.subtract      = sub_trap && (term == TERM_TRAP);
    ctl.apply         = (state == S_APPLY);
    ctl.first_from_y3 = closed;
    case (term)
      TERM_TRAP: begin
        ctl.coef    = {{(CW-TW){1'b0}}, h1};
        ctl.divisor = DIV_TRAP;
      end
      TERM_SUM3: begin
        ctl.coef    = {{(CW-TW-1){1'b0}}, hs};
        ctl.divisor = DIV_SUM3;
      end
      TERM_LEFT: begin
        ctl.coef    = a_h2;
        ctl.divisor = {six_h1, 16'd0};
      end
      TERM_RIGHT: begin
        ctl.coef    = a_h1;
        ctl.divisor = {six_h2, 16'd0};
      end
      default: begin
        ctl.coef    = {{(CW-TW){1'b0}}, h1};
        ctl.divisor = DIV_TRAP;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CHANNELS; gi++) begin : g_lane
      logic signed [VW-1:0] lane_val;
      if (gi < FIELDS) begin : g_field
        assign lane_val = s_tdata[TW + gi*VW +: VW];
      end else begin : g_zero
        assign lane_val = '0;
      end
      rsi_lane u_lane (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl),
        .value (lane_val),
        .done  (lane_done[gi]),
        .area  (lane_area[gi])
      );
    end
    // merge: lanes onto the output fields, absent channels read zero
    for (gi = 0; gi < FIELDS; gi++) begin : g_merge
      if (gi < CHANNELS) begin : g_used
        assign out_data[gi*AW +: AW] = lane_area[gi];
      end else begin : g_unused
        assign out_data[gi*AW +: AW] = '0;
      end
    end
  endgenerate

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_EMPTY;
      first_time <= '0;
      mid_time   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (ph_eff)
              PH_ONE: begin
                mid_time <= t_in;
                phase    <= PH_TWO;
                state    <= S_PREP;
              end
              PH_TWO: begin
                first_time <= t_in;
                phase      <= PH_ONE;
                state      <= S_PREP;
              end
              default: begin
                first_time <= t_in;
                phase      <= PH_ONE;
                state      <= S_APPLY;
              end
            endcase
          end
        end
        S_PREP: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (all_done) begin
            state <= (term == last_term) ? S_APPLY : S_PREP;
          end
        end
        S_APPLY: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // per-beat working values
  always_ff @(posedge clk) begin
    if (accept) begin
      h1        <= h1_in;
      h2        <= h2_in;
      hs        <= {1'b0, h1_in} + {1'b0, h2_in};
      term      <= TERM_TRAP;
      closed    <= (ph_eff == PH_TWO);
      degen     <= degen_in;
      sub_trap  <= (ph_eff == PH_TWO);
      last_term <= ((ph_eff == PH_TWO) && !degen_in) ? TERM_RIGHT : TERM_TRAP;
    end else if ((state == S_RUN) && all_done && (term != last_term)) begin
      term <= term + 2'd1;
    end
    if (state == S_PREP) begin
      a_h1 <= hs * h1;
      a_h2 <= hs * h2;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      m_tdata <= out_data;
      m_tuser <= {degen, closed};
    end
  end

  `RSI_ASSERT_IMP(a_lanes_lockstep, |lane_done, &lane_done, "lanes out of step")
  `RSI_ASSERT_IMP(a_done_in_run, lane_done[0], state == S_RUN, "term finished outside run")
  `RSI_ASSERT_NXT(a_out_load, (state == S_OUT) && out_free, m_tvalid, "result not loaded")
  `RSI_ASSERT_IMP(a_degen_closed, m_tvalid && m_tuser[1], m_tuser[0], "degenerate without panel")

endmodule

>>> tb/running_simpson_integrator_tb.sv
// Testbench for the running Simpson integrator: directed table plus random sample streams.
`timescale 1ns / 100ps
module running_simpson_integrator_tb;
  import rsi_pkg::*;

  typedef struct {
    bit                 restart;
    logic [31:0]        stamp;
    logic signed [31:0] val [4];
  } sample_t;

  typedef struct {
    logic [47:0] area [4];
    bit          closed;
    bit          degen;
  } areas_t;

  // one directed row: the sample and, where obvious, the typed-in result
  typedef struct {
    sample_t smp;
    bit      typed;
    areas_t  res;
  } row_t;

  localparam logic [63:0] CLAMP   = 64'd1 << 50;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< 47) - 1;
  localparam logic signed [63:0] SAT_LO = -(64'sd1 <<< 47);
  localparam int N_RANDOM = 700;
  localparam int TAIL     = 600;   // longer than a full panel close

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic [0:0]       s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;

  running_simpson_integrator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // integrator state as the testbench sees it
  logic [1:0]         pair_phase;
  logic [31:0]        held_first_t;
  logic [31:0]        held_mid_t;
  logic signed [63:0] held_first_v [4];
  logic signed [63:0] held_mid_v   [4];
  logic signed [63:0] run_area     [4];

  areas_t pending_areas [$];
  int     n_errors;
  bit     stim_done;

  // floor(a*b*y/d) with magnitude clamped to 2^50
  function automatic logic signed [63:0] panel_term(logic [63:0] a, logic [63:0] b,
                                                     logic signed [63:0] y, logic [63:0] d);
    logic [127:0] prod;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [63:0]  mag;
    logic [63:0]  q;
    logic         neg;
    if (d == 0) begin
      return 0;
    end
    neg  = y < 0;
    mag  = neg ? -y : y;
    prod = {64'd0, a} * {64'd0, b} * {64'd0, mag};
    quo  = prod / {64'd0, d};
    rem  = prod % {64'd0, d};
    q    = (quo[127:64] != 0) ? CLAMP : quo[63:0];
    if (q > CLAMP) begin
      q = CLAMP;
    end
    if (neg && rem != 0) begin
      q = q + 1;
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] clip48(logic signed [63:0] v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // advance the integrator by one accepted sample and return its result
  function automatic areas_t integrate(sample_t s);
    areas_t             r;
    logic [31:0]        h1;
    logic [31:0]        h2;
    logic [63:0]        hs;
    logic signed [63:0] y1, y2, y3, delta;
    r.closed = 0;
    r.degen  = 0;
    if (s.restart) begin
      foreach (run_area[i]) run_area[i] = 0;
      pair_phase = 0;
    end
    if (pair_phase == 1) begin
      h1 = s.stamp - held_first_t;
      held_mid_t = s.stamp;
      for (int i = 0; i < 4; i++) begin
        held_mid_v[i] = s.val[i];
        run_area[i] = clip48(run_area[i] +
                      panel_term(h1, 1, held_first_v[i] + s.val[i], 64'd131072));
      end
      pair_phase = 2;
    end else if (pair_phase == 2) begin
      h1 = held_mid_t - held_first_t;
      h2 = s.stamp - held_mid_t;
      hs = 64'(h1) + 64'(h2);
      r.closed = 1;
      r.degen  = (h1 == 0) || (h2 == 0);
      for (int i = 0; i < 4; i++) begin
        y1 = held_first_v[i];
        y2 = held_mid_v[i];
        y3 = s.val[i];
        delta = -panel_term(h1, 1, y1 + y2, 64'd131072);
        if (!r.degen) begin
          delta += panel_term(hs, 1, y1 + y2 + y3, 64'd196608);
          delta += panel_term(hs, h2, y2 - y1, 64'd6 * h1 * 64'd65536);
          delta += panel_term(hs, h1, y2 - y3, 64'd6 * h2 * 64'd65536);
        end
        run_area[i] = clip48(run_area[i] + delta);
        held_first_v[i] = y3;
      end
      held_first_t = s.stamp;
      pair_phase = 1;
    end else begin
      // no point held yet (phase 3 cannot occur; treated alike)
      held_first_t = s.stamp;
      for (int i = 0; i < 4; i++) held_first_v[i] = s.val[i];
      pair_phase = 1;
    end
    for (int i = 0; i < 4; i++) r.area[i] = run_area[i][47:0];
    return r;
  endfunction

  function automatic row_t mk_row(bit rs, logic [31:0] t, logic signed [31:0] a,
                                  logic signed [31:0] b, logic signed [31:0] c,
                                  logic signed [31:0] d, bit typed, bit cl, bit dg);
    row_t r;
    r.smp.restart = rs;
    r.smp.stamp   = t;
    r.smp.val[0]  = a;
    r.smp.val[1]  = b;
    r.smp.val[2]  = c;
    r.smp.val[3]  = d;
    r.typed       = typed;
    foreach (r.res.area[i]) r.res.area[i] = '0;
    r.res.closed  = cl;
    r.res.degen   = dg;
    return r;
  endfunction

  // random but mostly well-formed: rising stamps with varied spacing
  function automatic sample_t random_sample(logic [31:0] last_t);
    sample_t s;
    int      k;
    s.restart = ($urandom_range(0, 99) < 4);
    k = $urandom_range(0, 99);
    if (k < 8)       s.stamp = last_t;                                // zero spacing
    else if (k < 70) s.stamp = last_t + $urandom_range(1, 32'h0004_0000);
    else if (k < 85) s.stamp = last_t + $urandom_range(1, 32'h0100_0000);
    else if (k < 92) s.stamp = last_t + $urandom;                     // long, may wrap
    else if (k < 96) s.stamp = last_t - $urandom_range(1, 32'h0001_0000); // goes back
    else             s.stamp = $urandom;
    for (int i = 0; i < 4; i++) begin
      k = $urandom_range(0, 99);
      if (k < 55)      s.val[i] = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      else if (k < 85) s.val[i] = $urandom;
      else if (k < 92) s.val[i] = 32'sh7FFF_FFFF;
      else             s.val[i] = 32'sh8000_0000;
    end
    return s;
  endfunction

  // present one sample and wait for its beat; the prediction is taken on acceptance
  task automatic send_beat(sample_t s, bit typed, areas_t typed_res);
    areas_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= {s.val[3], s.val[2], s.val[1], s.val[0], s.stamp};
    s_tuser  <= s.restart;
    do @(posedge clk); while (!s_tready);
    r = integrate(s);
    pending_areas.push_back(typed ? typed_res : r);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: alternates free-flowing stretches with random stalls
  int rx_cnt;
  bit rx_choppy;
  always @(posedge clk) begin
    if (rst) begin
      rx_cnt    <= 0;
      rx_choppy <= 1'b0;
      m_tready  <= 1'b0;
    end else begin
      rx_cnt <= rx_cnt + 1;
      if (rx_cnt % 700 == 699) rx_choppy <= ~rx_choppy;
      m_tready <= rx_choppy ? ($urandom_range(0, 9) < 4) : 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    areas_t       e;
    logic [47:0]  got;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_areas.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        e = pending_areas.pop_front();
        for (int i = 0; i < 4; i++) begin
          got = m_tdata[i*AW +: AW];
          if (got !== e.area[i]) begin
            $error("area_%c expected %h got %h", 8'(8'h61 + i), e.area[i], got);
            n_errors++;
          end
        end
        if (m_tuser[0] !== e.closed) begin
          $error("pair_closed expected %0d got %0d", e.closed, m_tuser[0]);
          n_errors++;
        end
        if (m_tuser[1] !== e.degen) begin
          $error("degenerate expected %0d got %0d", e.degen, m_tuser[1]);
          n_errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    row_t        rows [$];
    sample_t     s;
    areas_t      none;
    logic [31:0] last_t;
    int          burst;
    n_errors     = 0;
    stim_done    = 0;
    pair_phase   = 0;
    held_first_t = 0;
    held_mid_t   = 0;
    foreach (run_area[i]) begin
      run_area[i] = 0;
      held_first_v[i] = 0;
      held_mid_v[i] = 0;
    end
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first sample stores only; zero spacings add nothing; restart clears
    rows.push_back(mk_row(1, 32'h0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 0, 0));
    rows.push_back(mk_row(0, 32'h0, 32'sh1234_5678, -5, 32'sh7FFF_FFFF, 7, 1, 0, 0));
    rows.push_back(mk_row(0, 32'h0, 1, 2, 3, 4, 1, 1, 1));
    rows.push_back(mk_row(0, 32'h0001_0000, 32'sh0001_0000, -32'sh0001_0000, 0, 5, 0, 0, 0));
    rows.push_back(mk_row(0, 32'h0003_0000, 32'sh0002_0000, 32'sh0003_0000, 9, -9, 0, 0, 0));
    rows.push_back(mk_row(0, 32'h0004_0000, 32'sh0001_0000, 32'sh7FFF_FFFF, -1, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 32'h0004_0000, 32'sh0005_0000, 3, 1, 1, 0, 0, 0));
    rows.push_back(mk_row(0, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh8000_0000, 0, 0, 0));
    rows.push_back(mk_row(0, 32'h0000_0005, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0));
    rows.push_back(mk_row(0, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh8000_0000, 0, 0, 0));
    rows.push_back(mk_row(0, 32'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh8000_0000, 0, 0, 0));
    rows.push_back(mk_row(0, 32'hFFFF_FFFE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh8000_0000, 0, 0, 0));
    rows.push_back(mk_row(0, 32'h7FFF_FFFD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh8000_0000, 0, 0, 0));
    rows.push_back(mk_row(1, 32'h1234_5678, 32'sh5555_5555, 32'shAAAA_AAAA, 1, -1, 1, 0, 0));
    rows.push_back(mk_row(0, 32'h1234_5679, 32'sh0000_0001, 32'sh0000_0002, 3, 4, 0, 0, 0));
    rows.push_back(mk_row(0, 32'h1235_5679, 32'shFFFF_0000, 32'sh0001_0000, 3, 4, 0, 0, 0));
    rows.push_back(mk_row(0, 32'h1234_0000, 32'sh0000_1000, 32'sh7000_0000, -3, 4, 0, 0, 0));

    foreach (rows[i]) begin
      send_beat(rows[i].smp, rows[i].typed, rows[i].res);
      if (i % 3 == 2) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end

    // random part: bursts of beats separated by idle gaps
    last_t = rows[rows.size()-1].smp.stamp;
    foreach (none.area[i]) none.area[i] = '0;
    none.closed = 0;
    none.degen  = 0;
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 300)) @(posedge clk);
        end
      end
      burst--;
      s = random_sample(last_t);
      last_t = s.stamp;
      send_beat(s, 0, none);
    end
    s_tvalid <= 1'b0;
    stim_done = 1;

    while (pending_areas.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (n_errors == 0 && !m_tvalid) begin
      $display("simulation ok");
    end else begin
      if (m_tvalid) $error("unexpected result beat left at the end");
      $display("simulation failed");
    end
    $finish;
  end

  // run limit, well above the slowest correct run
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/rsi_pkg.sv
design/rsi_term.sv
design/rsi_lane.sv
design/running_simpson_integrator.sv
tb/running_simpson_integrator_tb.sv
